// File: rtl/tsoprms_pkg.sv
// ----------------------------------------------------------------------------
// tsoprms_pkg
// Shared widths, constants, command codes and control structs of the
// two-state order parameter RMS error unit.
// ----------------------------------------------------------------------------
package tsoprms_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int MIX_SHIFT     = 14;
    localparam int VAL_W         = 16;
    localparam int MODEL_W       = 18;
    localparam int RMS_W         = 20;
    localparam int SUM_W         = 48;
    localparam int MAX_ITEMS_DEF = 1024;
    localparam int MUL_W         = 32;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int ACC_W         = PROD_W + 2;
    localparam int PR_W          = 48;
    localparam int NUM_W         = 2 * MODEL_W;
    localparam int DIV_NUM_W     = NUM_W + FRAC_BITS;
    localparam int DIV_DEN_W     = 32;
    localparam int SQRT_OP_W     = 42;
    localparam int MEAN_W        = 40 - FRAC_BITS + 1;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;

    localparam logic [MODEL_W-1:0]   MODEL_MAX  = '1;
    localparam logic [RMS_W-1:0]     RMS_MAX    = '1;
    localparam logic [SUM_W-1:0]     SUM_MAX    = '1;
    localparam logic [DIV_NUM_W-1:0] MEAN_LIMIT = DIV_NUM_W'(1) << (40 - FRAC_BITS);

    // Configuration register indexes.
    localparam logic [1:0] REG_WEIGHT_FIRST  = 2'd0;
    localparam logic [1:0] REG_WEIGHT_SECOND = 2'd1;
    localparam logic [1:0] REG_MODE          = 2'd2;

    typedef logic [3:0] t_mul_sel;
    localparam t_mul_sel MUL_NONE    = 4'd0;
    localparam t_mul_sel MUL_W1_S    = 4'd1;
    localparam t_mul_sel MUL_W2_C    = 4'd2;
    localparam t_mul_sel MUL_W1_W1   = 4'd3;
    localparam t_mul_sel MUL_P_S     = 4'd4;
    localparam t_mul_sel MUL_W2_W2   = 4'd5;
    localparam t_mul_sel MUL_P_C     = 4'd6;
    localparam t_mul_sel MUL_S_C     = 4'd7;
    localparam t_mul_sel MUL_W1_W2   = 4'd8;
    localparam t_mul_sel MUL_P_R     = 4'd9;
    localparam t_mul_sel MUL_TLO_MAG = 4'd10;
    localparam t_mul_sel MUL_THI_MAG = 4'd11;
    localparam t_mul_sel MUL_D_D     = 4'd12;
    localparam t_mul_sel MUL_M_M     = 4'd13;

    typedef logic [2:0] t_acc_sel;
    localparam t_acc_sel ACC_HOLD     = 3'd0;
    localparam t_acc_sel ACC_LOAD     = 3'd1;
    localparam t_acc_sel ACC_ADD      = 3'd2;
    localparam t_acc_sel ACC_LOAD_SH  = 3'd3;
    localparam t_acc_sel ACC_ADD_SH   = 3'd4;
    localparam t_acc_sel ACC_CROSS_LO = 3'd5;
    localparam t_acc_sel ACC_CROSS_HI = 3'd6;

    typedef logic [1:0] t_rms_sel;
    localparam t_rms_sel RMS_ZERO = 2'd0;
    localparam t_rms_sel RMS_SAT  = 2'd1;
    localparam t_rms_sel RMS_ROOT = 2'd2;

    localparam logic SRC_ITEM = 1'b0;
    localparam logic SRC_MEAN = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0] weight_first;
        logic [VAL_W-1:0] weight_second;
        logic             interaction_mode;
    } t_cfg;

    typedef struct packed {
        logic     load_in;
        t_mul_sel mul_sel;
        t_acc_sel acc_sel;
        logic     t_load;
        logic     num_load;
        logic     model_load;
        logic     sqrt_start;
        logic     sqrt_src;
        logic     div_start;
        logic     div_src;
        logic     err_accum;
        logic     fault_set;
        logic     rms_load;
        t_rms_sel rms_sel;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic m_zero;
        logic count_full;
        logic count_zero;
        logic last;
        logic mean_big;
        logic div_done;
        logic div_busy;
        logic sqrt_done;
    } t_stat;

endpackage

// File: rtl/tsoprms_if.sv
// ----------------------------------------------------------------------------
// tsoprms_in_if / tsoprms_out_if
// Valid/ready channels for residue words and result words.
// ----------------------------------------------------------------------------
interface tsoprms_in_if;
    logic                                valid;
    logic                                ready;
    logic [tsoprms_pkg::VAL_W-1:0]        semi_value;
    logic [tsoprms_pkg::VAL_W-1:0]        close_value;
    logic [tsoprms_pkg::VAL_W-1:0]        measured_value;
    logic signed [tsoprms_pkg::VAL_W-1:0] cross_term;
    logic                                last_item;

    modport source (output valid, semi_value, close_value, measured_value, cross_term,
                    last_item, input ready);
    modport sink (input valid, semi_value, close_value, measured_value, cross_term,
                  last_item, output ready);
endinterface

interface tsoprms_out_if;
    logic                            valid;
    logic                            ready;
    logic [tsoprms_pkg::MODEL_W-1:0] model_value;
    logic [tsoprms_pkg::RMS_W-1:0]   rms_error;
    logic                            rms_valid;
    logic                            divide_fault;

    modport source (output valid, model_value, rms_error, rms_valid, divide_fault,
                    input ready);
    modport sink (input valid, model_value, rms_error, rms_valid, divide_fault,
                  output ready);
endinterface

// File: rtl/tsoprms_div.sv
// ----------------------------------------------------------------------------
// tsoprms_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsoprms_div #(
    parameter int NUM_W = tsoprms_pkg::DIV_NUM_W,
    parameter int DEN_W = tsoprms_pkg::DIV_DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CW = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb begin
        trial = {r_rem, r_quot[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The numerator shifts out at the top while quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// File: rtl/tsoprms_sqrt.sv
// ----------------------------------------------------------------------------
// tsoprms_sqrt
// Digit-by-digit integer square root, one root bit per cycle (floor).
// ----------------------------------------------------------------------------
module tsoprms_sqrt #(
    parameter int OP_W = tsoprms_pkg::SQRT_OP_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [OP_W-1:0]     i_op,
    output logic                o_done,
    output logic [OP_W/2-1:0]   o_root
);
    localparam int RES_W = OP_W / 2;
    localparam int CW    = $clog2(RES_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [OP_W-1:0]  r_op;
    logic [RES_W+1:0] r_rem;
    logic [RES_W-1:0] r_root;
    logic [RES_W+3:0] trial;
    logic [RES_W+3:0] sub;
    logic [RES_W+3:0] diff;
    logic             ge;

    always_comb begin
        trial = {r_rem, r_op[OP_W-1:OP_W-2]};
        sub   = {2'b00, r_root, 2'b01};
        diff  = trial - sub;
        ge    = trial >= sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(RES_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= i_op;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_op   <= r_op << 2;
            r_rem  <= ge ? diff[RES_W+1:0] : trial[RES_W+1:0];
            r_root <= {r_root[RES_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// File: rtl/tsoprms_dp.sv
// ----------------------------------------------------------------------------
// tsoprms_dp
// Datapath: input capture, shared multiplier, mixing accumulator, error sum,
// divider, square-root unit and the output word register.
// ----------------------------------------------------------------------------
module tsoprms_dp #(
    parameter int MAX_ITEMS = tsoprms_pkg::MAX_ITEMS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tsoprms_pkg::t_cfg                     i_cfg,
    input  tsoprms_pkg::t_cmd                     i_cmd,
    output tsoprms_pkg::t_stat                    o_stat,
    input  logic [tsoprms_pkg::VAL_W-1:0]         i_semi_value,
    input  logic [tsoprms_pkg::VAL_W-1:0]         i_close_value,
    input  logic [tsoprms_pkg::VAL_W-1:0]         i_measured_value,
    input  logic signed [tsoprms_pkg::VAL_W-1:0]  i_cross_term,
    input  logic                                  i_last_item,
    output logic [tsoprms_pkg::MODEL_W-1:0]       o_model_value,
    output logic [tsoprms_pkg::RMS_W-1:0]         o_rms_error,
    output logic                                  o_rms_valid,
    output logic                                  o_divide_fault
);
    localparam int VAL_W     = tsoprms_pkg::VAL_W;
    localparam int MODEL_W   = tsoprms_pkg::MODEL_W;
    localparam int RMS_W     = tsoprms_pkg::RMS_W;
    localparam int SUM_W     = tsoprms_pkg::SUM_W;
    localparam int MUL_W     = tsoprms_pkg::MUL_W;
    localparam int PROD_W    = tsoprms_pkg::PROD_W;
    localparam int ACC_W     = tsoprms_pkg::ACC_W;
    localparam int PR_W      = tsoprms_pkg::PR_W;
    localparam int NUM_W     = tsoprms_pkg::NUM_W;
    localparam int DIV_NUM_W = tsoprms_pkg::DIV_NUM_W;
    localparam int DIV_DEN_W = tsoprms_pkg::DIV_DEN_W;
    localparam int SQRT_OP_W = tsoprms_pkg::SQRT_OP_W;
    localparam int RES_W     = SQRT_OP_W / 2;
    localparam int MEAN_W    = tsoprms_pkg::MEAN_W;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int SH_LIN    = tsoprms_pkg::FRAC_BITS;
    localparam int SH_INT    = 2 * tsoprms_pkg::FRAC_BITS + tsoprms_pkg::MIX_SHIFT;

    logic [VAL_W-1:0]     r_s;
    logic [VAL_W-1:0]     r_c;
    logic [VAL_W-1:0]     r_m;
    logic [VAL_W-1:0]     r_p;
    logic                 r_last;
    logic [PROD_W-1:0]    r_prod;
    logic [PR_W-1:0]      r_t;
    logic [ACC_W-1:0]     r_acc;
    logic [MODEL_W-1:0]   r_model;
    logic [NUM_W-1:0]     r_num;
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_count;
    logic                 r_fault;
    logic [RMS_W-1:0]     r_rms;
    logic [MODEL_W-1:0]   r_out_model;
    logic [RMS_W-1:0]     r_out_rms;
    logic                 r_out_last;
    logic                 r_out_fault;

    logic [MUL_W-1:0]     mul_a;
    logic [MUL_W-1:0]     mul_b;
    logic [PROD_W-1:0]    mul_res;
    logic [ACC_W-1:0]     prod_x;
    logic [ACC_W-1:0]     n_acc;
    logic                 cross_neg;
    logic [VAL_W-1:0]     mag;
    logic [MODEL_W-1:0]   d;
    logic [ACC_W-1:0]     mix_shifted;
    logic [MODEL_W-1:0]   model_sat;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_quot;
    logic                 div_busy;
    logic                 div_done;
    logic [SQRT_OP_W-1:0] sqrt_op;
    logic [RES_W-1:0]     root;
    logic                 sqrt_done;
    logic [SUM_W-1:0]     q_sat;
    logic [SUM_W:0]       sum_add;
    logic [RMS_W-1:0]     root_sat;

    always_comb begin
        cross_neg = r_p[VAL_W-1];
        mag       = cross_neg ? (~r_p + 1'b1) : r_p;
        d         = (r_model > MODEL_W'(r_m)) ? (r_model - MODEL_W'(r_m))
                                              : (MODEL_W'(r_m) - r_model);
    end

    always_comb begin
        case (i_cmd.mul_sel)
            tsoprms_pkg::MUL_W1_S: begin
                mul_a = MUL_W'(i_cfg.weight_first);
                mul_b = MUL_W'(r_s);
            end
            tsoprms_pkg::MUL_W2_C: begin
                mul_a = MUL_W'(i_cfg.weight_second);
                mul_b = MUL_W'(r_c);
            end
            tsoprms_pkg::MUL_W1_W1: begin
                mul_a = MUL_W'(i_cfg.weight_first);
                mul_b = MUL_W'(i_cfg.weight_first);
            end
            tsoprms_pkg::MUL_P_S: begin
                mul_a = r_prod[MUL_W-1:0];
                mul_b = MUL_W'(r_s);
            end
            tsoprms_pkg::MUL_W2_W2: begin
                mul_a = MUL_W'(i_cfg.weight_second);
                mul_b = MUL_W'(i_cfg.weight_second);
            end
            tsoprms_pkg::MUL_P_C: begin
                mul_a = r_prod[MUL_W-1:0];
                mul_b = MUL_W'(r_c);
            end
            tsoprms_pkg::MUL_S_C: begin
                mul_a = MUL_W'(r_s);
                mul_b = MUL_W'(r_c);
            end
            tsoprms_pkg::MUL_W1_W2: begin
                mul_a = MUL_W'(i_cfg.weight_first);
                mul_b = MUL_W'(i_cfg.weight_second);
            end
            tsoprms_pkg::MUL_P_R: begin
                mul_a = r_prod[MUL_W-1:0];
                mul_b = MUL_W'(root);
            end
            tsoprms_pkg::MUL_TLO_MAG: begin
                mul_a = r_t[MUL_W-1:0];
                mul_b = MUL_W'(mag);
            end
            tsoprms_pkg::MUL_THI_MAG: begin
                mul_a = MUL_W'(r_t[PR_W-1:MUL_W]);
                mul_b = MUL_W'(mag);
            end
            tsoprms_pkg::MUL_D_D: begin
                mul_a = MUL_W'(d);
                mul_b = MUL_W'(d);
            end
            tsoprms_pkg::MUL_M_M: begin
                mul_a = MUL_W'(r_m);
                mul_b = MUL_W'(r_m);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_res = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // The accumulator is two's complement; the cross term may pull it negative.
    always_comb begin
        prod_x = ACC_W'(r_prod);
        case (i_cmd.acc_sel)
            tsoprms_pkg::ACC_LOAD:     n_acc = prod_x;
            tsoprms_pkg::ACC_ADD:      n_acc = r_acc + prod_x;
            tsoprms_pkg::ACC_LOAD_SH:  n_acc = prod_x << tsoprms_pkg::MIX_SHIFT;
            tsoprms_pkg::ACC_ADD_SH:   n_acc = r_acc + (prod_x << tsoprms_pkg::MIX_SHIFT);
            tsoprms_pkg::ACC_CROSS_LO: n_acc = cross_neg ? (r_acc - prod_x) : (r_acc + prod_x);
            tsoprms_pkg::ACC_CROSS_HI: n_acc = cross_neg ? (r_acc - (prod_x << MUL_W))
                                                         : (r_acc + (prod_x << MUL_W));
            default:                   n_acc = r_acc;
        endcase
    end

    always_comb begin
        mix_shifted = i_cfg.interaction_mode ? (r_acc >> SH_INT) : (r_acc >> SH_LIN);
        if (r_acc[ACC_W-1]) begin
            model_sat = '0;
        end else if (mix_shifted > ACC_W'(tsoprms_pkg::MODEL_MAX)) begin
            model_sat = tsoprms_pkg::MODEL_MAX;
        end else begin
            model_sat = mix_shifted[MODEL_W-1:0];
        end
    end

    always_comb begin
        if (i_cmd.div_src == tsoprms_pkg::SRC_MEAN) begin
            div_num = DIV_NUM_W'(r_sum);
            div_den = DIV_DEN_W'(r_count);
        end else begin
            div_num = DIV_NUM_W'(r_num) << tsoprms_pkg::FRAC_BITS;
            div_den = r_prod[DIV_DEN_W-1:0];
        end
        if (i_cmd.sqrt_src == tsoprms_pkg::SRC_MEAN) begin
            sqrt_op = SQRT_OP_W'(div_quot[MEAN_W-1:0]) << tsoprms_pkg::FRAC_BITS;
        end else begin
            sqrt_op = SQRT_OP_W'(r_prod[MUL_W-1:0]);
        end
        q_sat    = (div_quot > DIV_NUM_W'(tsoprms_pkg::SUM_MAX)) ? tsoprms_pkg::SUM_MAX
                                                                 : div_quot[SUM_W-1:0];
        sum_add  = {1'b0, r_sum} + {1'b0, q_sat};
        root_sat = (root > RES_W'(tsoprms_pkg::RMS_MAX)) ? tsoprms_pkg::RMS_MAX
                                                         : root[RMS_W-1:0];
    end

    tsoprms_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    tsoprms_sqrt #(
        .OP_W (SQRT_OP_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_op    (sqrt_op),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_s    <= i_semi_value;
            r_c    <= i_close_value;
            r_m    <= i_measured_value;
            r_p    <= i_cross_term;
            r_last <= i_last_item;
        end
        if (i_cmd.mul_sel != tsoprms_pkg::MUL_NONE) begin
            r_prod <= mul_res;
        end
        r_acc <= n_acc;
        if (i_cmd.t_load) begin
            r_t <= r_prod[PR_W-1:0];
        end
        if (i_cmd.num_load) begin
            r_num <= r_prod[NUM_W-1:0];
        end
        if (i_cmd.model_load) begin
            r_model <= model_sat;
        end
        if (i_cmd.rms_load) begin
            case (i_cmd.rms_sel)
                tsoprms_pkg::RMS_SAT:  r_rms <= tsoprms_pkg::RMS_MAX;
                tsoprms_pkg::RMS_ROOT: r_rms <= root_sat;
                default:               r_rms <= '0;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_model <= r_model;
            r_out_rms   <= r_rms;
            r_out_last  <= r_last;
            r_out_fault <= r_fault;
        end
    end

    // Set state: the running sum, the count and the sticky fault clear
    // when the last word of a set is handed to the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_fault <= 1'b0;
        end else if (i_cmd.out_load && r_last) begin
            r_sum   <= '0;
            r_count <= '0;
            r_fault <= 1'b0;
        end else begin
            if (i_cmd.err_accum) begin
                r_sum   <= sum_add[SUM_W] ? tsoprms_pkg::SUM_MAX : sum_add[SUM_W-1:0];
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.fault_set) begin
                r_fault <= 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.mode       = i_cfg.interaction_mode;
        o_stat.m_zero     = (r_m == '0);
        o_stat.count_full = (r_count >= CNT_W'(MAX_ITEMS));
        o_stat.count_zero = (r_count == '0);
        o_stat.last       = r_last;
        o_stat.mean_big   = (div_quot > tsoprms_pkg::MEAN_LIMIT);
        o_stat.div_done   = div_done;
        o_stat.div_busy   = div_busy;
        o_stat.sqrt_done  = sqrt_done;
    end

    assign o_model_value  = r_out_model;
    assign o_rms_error    = r_out_rms;
    assign o_rms_valid    = r_out_last;
    assign o_divide_fault = r_out_fault;
endmodule

// File: rtl/tsoprms_ctrl.sv
// ----------------------------------------------------------------------------
// tsoprms_ctrl
// Sequencer: steps the datapath through mixing, error and RMS phases and
// runs the input and output handshakes.
// ----------------------------------------------------------------------------
module tsoprms_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  tsoprms_pkg::t_stat i_stat,
    output tsoprms_pkg::t_cmd  o_cmd
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_L1    = 5'd1;
    localparam logic [4:0] S_L2    = 5'd2;
    localparam logic [4:0] S_L3    = 5'd3;
    localparam logic [4:0] S_I1    = 5'd4;
    localparam logic [4:0] S_I2    = 5'd5;
    localparam logic [4:0] S_I3    = 5'd6;
    localparam logic [4:0] S_I4    = 5'd7;
    localparam logic [4:0] S_I5    = 5'd8;
    localparam logic [4:0] S_I6    = 5'd9;
    localparam logic [4:0] S_SQW   = 5'd10;
    localparam logic [4:0] S_I7    = 5'd11;
    localparam logic [4:0] S_I8    = 5'd12;
    localparam logic [4:0] S_I9    = 5'd13;
    localparam logic [4:0] S_I10   = 5'd14;
    localparam logic [4:0] S_I11   = 5'd15;
    localparam logic [4:0] S_MODEL = 5'd16;
    localparam logic [4:0] S_ERR   = 5'd17;
    localparam logic [4:0] S_E2    = 5'd18;
    localparam logic [4:0] S_E3    = 5'd19;
    localparam logic [4:0] S_E4    = 5'd20;
    localparam logic [4:0] S_FIN   = 5'd21;
    localparam logic [4:0] S_F2    = 5'd22;
    localparam logic [4:0] S_F3    = 5'd23;
    localparam logic [4:0] S_F4    = 5'd24;
    localparam logic [4:0] S_OUT   = 5'd25;

    logic [4:0]        r_state;
    logic [4:0]        n_state;
    logic              r_out_valid;
    logic              n_out_valid;
    tsoprms_pkg::t_cmd cmd;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = i_stat.mode ? S_I1 : S_L1;
                end
            end
            S_L1: begin
                cmd.mul_sel = tsoprms_pkg::MUL_W1_S;
                n_state     = S_L2;
            end
            S_L2: begin
                cmd.acc_sel = tsoprms_pkg::ACC_LOAD;
                cmd.mul_sel = tsoprms_pkg::MUL_W2_C;
                n_state     = S_L3;
            end
            S_L3: begin
                cmd.acc_sel = tsoprms_pkg::ACC_ADD;
                n_state     = S_MODEL;
            end
            S_I1: begin
                cmd.mul_sel = tsoprms_pkg::MUL_W1_W1;
                n_state     = S_I2;
            end
            S_I2: begin
                cmd.mul_sel = tsoprms_pkg::MUL_P_S;
                n_state     = S_I3;
            end
            S_I3: begin
                cmd.acc_sel = tsoprms_pkg::ACC_LOAD_SH;
                cmd.mul_sel = tsoprms_pkg::MUL_W2_W2;
                n_state     = S_I4;
            end
            S_I4: begin
                cmd.mul_sel = tsoprms_pkg::MUL_P_C;
                n_state     = S_I5;
            end
            S_I5: begin
                cmd.acc_sel = tsoprms_pkg::ACC_ADD_SH;
                cmd.mul_sel = tsoprms_pkg::MUL_S_C;
                n_state     = S_I6;
            end
            S_I6: begin
                cmd.sqrt_start = 1'b1;
                cmd.sqrt_src   = tsoprms_pkg::SRC_ITEM;
                cmd.mul_sel    = tsoprms_pkg::MUL_W1_W2;
                n_state        = S_SQW;
            end
            S_SQW: begin
                if (i_stat.sqrt_done) begin
                    n_state = S_I7;
                end
            end
            S_I7: begin
                cmd.mul_sel = tsoprms_pkg::MUL_P_R;
                n_state     = S_I8;
            end
            S_I8: begin
                cmd.t_load = 1'b1;
                n_state    = S_I9;
            end
            S_I9: begin
                cmd.mul_sel = tsoprms_pkg::MUL_TLO_MAG;
                n_state     = S_I10;
            end
            S_I10: begin
                cmd.acc_sel = tsoprms_pkg::ACC_CROSS_LO;
                cmd.mul_sel = tsoprms_pkg::MUL_THI_MAG;
                n_state     = S_I11;
            end
            S_I11: begin
                cmd.acc_sel = tsoprms_pkg::ACC_CROSS_HI;
                n_state     = S_MODEL;
            end
            S_MODEL: begin
                cmd.model_load = 1'b1;
                n_state        = S_ERR;
            end
            S_ERR: begin
                if (i_stat.m_zero) begin
                    cmd.fault_set = 1'b1;
                    n_state       = S_FIN;
                end else if (i_stat.count_full) begin
                    n_state = S_FIN;
                end else begin
                    cmd.mul_sel = tsoprms_pkg::MUL_D_D;
                    n_state     = S_E2;
                end
            end
            S_E2: begin
                cmd.num_load = 1'b1;
                cmd.mul_sel  = tsoprms_pkg::MUL_M_M;
                n_state      = S_E3;
            end
            S_E3: begin
                cmd.div_start = 1'b1;
                cmd.div_src   = tsoprms_pkg::SRC_ITEM;
                n_state       = S_E4;
            end
            S_E4: begin
                if (i_stat.div_done) begin
                    cmd.err_accum = 1'b1;
                    n_state       = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_stat.last || i_stat.count_zero) begin
                    cmd.rms_load = 1'b1;
                    cmd.rms_sel  = tsoprms_pkg::RMS_ZERO;
                    n_state      = S_OUT;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = tsoprms_pkg::SRC_MEAN;
                    n_state       = S_F2;
                end
            end
            S_F2: begin
                if (i_stat.div_done) begin
                    n_state = S_F3;
                end
            end
            S_F3: begin
                // The divider holds the mean, which feeds the root unit.
                cmd.div_src = tsoprms_pkg::SRC_MEAN;
                if (i_stat.mean_big) begin
                    cmd.rms_load = 1'b1;
                    cmd.rms_sel  = tsoprms_pkg::RMS_SAT;
                    n_state      = S_OUT;
                end else begin
                    cmd.sqrt_start = 1'b1;
                    cmd.sqrt_src   = tsoprms_pkg::SRC_MEAN;
                    n_state        = S_F4;
                end
            end
            S_F4: begin
                if (i_stat.sqrt_done) begin
                    cmd.rms_load = 1'b1;
                    cmd.rms_sel  = tsoprms_pkg::RMS_ROOT;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

// File: rtl/two_state_order_parameter_rms_error_unit.sv
// ----------------------------------------------------------------------------
// two_state_order_parameter_rms_error_unit
// Mixes two order parameters per residue, accumulates squared relative
// errors and reports the RMS error on the last residue of a set.
// ----------------------------------------------------------------------------
// One residue word is worked at a time. An interaction-mode word takes longer
// than a linear-mode word, as it adds a pass through the shared square-root
// unit. The last word of a set with counted words also divides the error sum
// by the count and, unless the mean is too large, takes the root of the mean.
// The bit-serial divider is shared between the per-word error and the mean.
// A finished result waits in an output register, so the next
// word is accepted while the previous result is still pending.
module two_state_order_parameter_rms_error_unit #(
    parameter int MAX_ITEMS = tsoprms_pkg::MAX_ITEMS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tsoprms_in_if.sink                          i_in,
    tsoprms_out_if.source                       o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tsoprms_pkg::ADDR_W-1:0]      paddr,
    input  logic [tsoprms_pkg::DATA_W-1:0]      pwdata,
    output logic [tsoprms_pkg::DATA_W-1:0]      prdata,
    output logic                                pready
);
    localparam int VAL_W  = tsoprms_pkg::VAL_W;
    localparam int DATA_W = tsoprms_pkg::DATA_W;
    localparam int ADDR_W = tsoprms_pkg::ADDR_W;

    tsoprms_pkg::t_cfg  r_cfg;
    tsoprms_pkg::t_cmd  cmd;
    tsoprms_pkg::t_stat stat;
    logic               wr_en;
    logic [1:0]         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                tsoprms_pkg::REG_WEIGHT_FIRST:  r_cfg.weight_first     <= pwdata[VAL_W-1:0];
                tsoprms_pkg::REG_WEIGHT_SECOND: r_cfg.weight_second    <= pwdata[VAL_W-1:0];
                tsoprms_pkg::REG_MODE:          r_cfg.interaction_mode <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tsoprms_pkg::REG_WEIGHT_FIRST:  prdata = DATA_W'(r_cfg.weight_first);
            tsoprms_pkg::REG_WEIGHT_SECOND: prdata = DATA_W'(r_cfg.weight_second);
            tsoprms_pkg::REG_MODE:          prdata = DATA_W'(r_cfg.interaction_mode);
            default:                        prdata = '0;
        endcase
    end

    tsoprms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tsoprms_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_semi_value     (i_in.semi_value),
        .i_close_value    (i_in.close_value),
        .i_measured_value (i_in.measured_value),
        .i_cross_term     (i_in.cross_term),
        .i_last_item      (i_in.last_item),
        .o_model_value    (o_out.model_value),
        .o_rms_error      (o_out.rms_error),
        .o_rms_valid      (o_out.rms_valid),
        .o_divide_fault   (o_out.divide_fault)
    );

`ifndef SYNTH
    // A word is worked alone: the input closes right after an acceptance.
    a_ready_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input stayed ready after a word was accepted");

    a_rms_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.rms_valid) |-> (o_out.rms_error == '0))
        else $error("rms error nonzero on a word that is not last");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider started while busy");
`endif
endmodule

// File: tb/sv/two_state_order_parameter_rms_error_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_state_order_parameter_rms_error_unit_test
// Drives residue words with random idling and back pressure through several
// weight and mode settings, predicts every result word and compares it.
// ----------------------------------------------------------------------------

class rms_error_board;
    logic [15:0] w_first;
    logic [15:0] w_second;
    logic        mix_mode;
    logic [63:0] err_sum;
    int unsigned residue_count;
    bit          zero_seen;
    logic [17:0] model_q[$];
    logic [19:0] rms_q[$];
    logic        flag_q[$];
    logic        fault_q[$];
    int          mismatches;

    function new();
        w_first = '0; w_second = '0; mix_mode = 1'b0;
        err_sum = '0; residue_count = 0; zero_seen = 0; mismatches = 0;
    endfunction

    function logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function logic [17:0] mixture(logic [15:0] s, logic [15:0] c, logic [15:0] p);
        logic [63:0] v, a, b, r, pr, mag, cr, pos, tot;
        if (!mix_mode) begin
            v = (64'(w_first) * s + 64'(w_second) * c) >> 16;
        end else begin
            a = (64'(w_first) * w_first * s) << 14;
            b = (64'(w_second) * w_second * c) << 14;
            r = floor_root(64'(s) * c);
            pr = 64'(w_first) * w_second * r;
            mag = p[15] ? 64'h10000 - p : 64'(p);
            cr = pr * mag;
            pos = a + b;
            if (!p[15]) tot = pos + cr;
            else tot = (cr > pos) ? 64'd0 : pos - cr;
            v = tot >> 46;
        end
        return (v > 64'd262143) ? 18'h3ffff : v[17:0];
    endfunction

    task note_residue(logic [15:0] s, logic [15:0] c, logic [15:0] m, logic [15:0] p,
                      logic last);
        logic [17:0] model;
        logic [63:0] d, q, mean, rms;
        model = mixture(s, c, p);
        rms = 0;
        if (m == 0) begin
            zero_seen = 1;
        end else if (residue_count < 1024) begin
            d = (model > m) ? model - m : m - model;
            q = ((d * d) << 16) / (64'(m) * m);
            if (q > 64'hffff_ffff_ffff) q = 64'hffff_ffff_ffff;
            err_sum = err_sum + q;
            if (err_sum > 64'hffff_ffff_ffff) err_sum = 64'hffff_ffff_ffff;
            residue_count++;
        end
        fault_q = {fault_q, zero_seen};
        if (last) begin
            if (residue_count != 0) begin
                mean = err_sum / residue_count;
                if (mean > (64'd1 << 24)) rms = 64'hfffff;
                else begin
                    rms = floor_root(mean << 16);
                    if (rms > 64'hfffff) rms = 64'hfffff;
                end
            end
            err_sum = 0; residue_count = 0; zero_seen = 0;
        end
        model_q = {model_q, model};
        rms_q = {rms_q, rms[19:0]};
        flag_q = {flag_q, last};
    endtask

    task report(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    task check_result(logic [17:0] model, logic [19:0] rms, logic rv, logic fault);
        if (model_q.size() == 0) begin
            report("unexpected word", 1, 0);
        end else begin
            if (model !== model_q[0]) report("model_value", model, model_q[0]);
            if (rms !== rms_q[0]) report("rms_error", rms, rms_q[0]);
            if (rv !== flag_q[0]) report("rms_valid", rv, flag_q[0]);
            if (fault !== fault_q[0]) report("divide_fault", fault, fault_q[0]);
            void'(model_q.pop_front()); void'(rms_q.pop_front());
            void'(flag_q.pop_front()); void'(fault_q.pop_front());
        end
    endtask
endclass

module two_state_order_parameter_rms_error_unit_test;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [tsoprms_pkg::ADDR_W-1:0] paddr;
    logic [tsoprms_pkg::DATA_W-1:0] pwdata;
    logic [tsoprms_pkg::DATA_W-1:0] prdata;
    logic pready;

    tsoprms_in_if  in_ch();
    tsoprms_out_if out_ch();

    two_state_order_parameter_rms_error_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    rms_error_board board = new();
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;
    longint cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 64'd3_000_000) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off while hold_off is set.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.model_value, out_ch.rms_error, out_ch.rms_valid,
                               out_ch.divide_fault);
    end

    task write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= tsoprms_pkg::ADDR_W'(idx) << 2; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            tsoprms_pkg::REG_WEIGHT_FIRST:  board.w_first = value[15:0];
            tsoprms_pkg::REG_WEIGHT_SECOND: board.w_second = value[15:0];
            tsoprms_pkg::REG_MODE:          board.mix_mode = value[0];
            default: ;
        endcase
    endtask

    task send_residue(logic [15:0] s, logic [15:0] c, logic [15:0] m, logic [15:0] p,
                      logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.semi_value <= s; in_ch.close_value <= c; in_ch.measured_value <= m;
        in_ch.cross_term <= p; in_ch.last_item <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_residue(s, c, m, p, last);
        @(negedge i_clk);
    endtask

    task drain();
        in_ch.valid <= 1'b0;
        while (board.model_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    // Mostly sets of a few residues, with zero measured values now and then.
    task random_residues(int count);
        logic [15:0] m;
        for (int k = 0; k < count; k++) begin
            m = ($urandom_range(30) == 0) ? 16'd0 :
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(65535, 256));
            send_residue(16'($urandom), 16'($urandom), m, 16'($urandom),
                         $urandom_range(7) == 0);
        end
        send_residue(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    endtask

    initial begin
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_ch.valid = 0; in_ch.semi_value = '0; in_ch.close_value = '0;
        in_ch.measured_value = '0; in_ch.cross_term = '0; in_ch.last_item = 0;
        hold_off = 0; send_idle_pct = 9; recv_idle_pct = 61;
        i_rst_n = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset weights, then extremes in both modes.
        send_residue(16'hffff, 16'hffff, 16'hffff, 16'h7fff, 1'b1);
        send_residue(16'h0, 16'h0, 16'h0, 16'h0, 1'b1);
        drain();
        write_reg(tsoprms_pkg::REG_WEIGHT_FIRST, 32'hffff_ffff);
        write_reg(tsoprms_pkg::REG_WEIGHT_SECOND, 32'h0001_ffff);
        write_reg(tsoprms_pkg::REG_MODE, 32'h0);
        send_residue(16'hffff, 16'hffff, 16'h0001, 16'h0, 1'b0);
        send_residue(16'hffff, 16'hffff, 16'hffff, 16'h0, 1'b0);
        send_residue(16'h8000, 16'h0001, 16'h0, 16'h8000, 1'b1);
        send_residue(16'h1234, 16'h4321, 16'h0, 16'h0, 1'b1);
        drain();
        write_reg(tsoprms_pkg::REG_MODE, 32'hffff_ffff);
        send_residue(16'hffff, 16'hffff, 16'h8000, 16'h7fff, 1'b0);
        send_residue(16'hffff, 16'hffff, 16'h8000, 16'h8000, 1'b0);
        send_residue(16'h0001, 16'hffff, 16'h0001, 16'h8000, 1'b0);
        send_residue(16'h4000, 16'h4000, 16'h4000, 16'hffff, 1'b1);
        send_residue(16'h0, 16'h0, 16'h0001, 16'h0, 1'b1);
        drain();

        // Long set past the item limit.
        write_reg(tsoprms_pkg::REG_WEIGHT_FIRST, 32'h8000);
        write_reg(tsoprms_pkg::REG_WEIGHT_SECOND, 32'h8000);
        write_reg(tsoprms_pkg::REG_MODE, 32'h0);
        for (int k = 0; k < 1030; k++)
            send_residue(16'($urandom), 16'($urandom), 16'($urandom_range(65535, 1)),
                         16'($urandom), k == 1029);
        drain();

        send_idle_pct = 9; recv_idle_pct = 61;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin send_idle_pct = 61; recv_idle_pct = 9; end
            if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
            write_reg(tsoprms_pkg::REG_WEIGHT_FIRST, (ph == 5) ? 32'h0 : $urandom);
            write_reg(tsoprms_pkg::REG_WEIGHT_SECOND, (ph == 1) ? 32'hffff : $urandom);
            write_reg(tsoprms_pkg::REG_MODE, 32'(ph[0]));
            if (ph == 3) begin
                // Receiver holds off while words keep coming, so input stalls.
                fork
                    begin hold_off = 1; repeat (600) @(negedge i_clk); hold_off = 0; end
                    random_residues(8);
                join
            end
            random_residues(60);
            drain();
        end

        if (board.mismatches == 0 && board.model_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
